### sv/hit_record_group_unpacker_defines.svh
// assertion helpers shared by the unpacker modules
`ifndef HIT_RECORD_GROUP_UNPACKER_DEFINES_SVH
`define HIT_RECORD_GROUP_UNPACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HRGU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define HRGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hrgu_pkg.sv
package hrgu_pkg;

  localparam int unsigned MAX_GROUPS = 1024;
  localparam int GRP_CNT_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  localparam int WORD_W          = 32;
  localparam int WORDS_PER_GROUP = 6;
  localparam int BUF_WORDS       = WORDS_PER_GROUP - 1;
  localparam int RECS            = 8;
  localparam int REC_W           = 22;
  localparam int POS_W           = 6;
  localparam int WID_W           = 5;
  localparam int BUNCH_W         = 12;
  localparam int GRP_IDX_W       = 10;
  localparam int ERR_W           = 4;
  localparam int CHAN_W          = 4;
  localparam int CNT_W           = 4;
  localparam int WPOS_W          = 3;
  localparam int IDX_W           = 3;

  localparam logic [ERR_W-1:0]  ERR_INCOMPLETE = 4'hf;
  localparam logic [WPOS_W-1:0] LAST_WORD_POS  = 3'd5;

  localparam logic [WORD_W-1:0] SRC_A_LO = 32'h0081_000A;
  localparam logic [WORD_W-1:0] SRC_A_HI = 32'h0081_004A;
  localparam logic [WORD_W-1:0] SRC_C_LO = 32'h0081_000C;
  localparam logic [WORD_W-1:0] SRC_C_HI = 32'h0081_004C;

  typedef enum logic [1:0] {
    MAP_A,
    MAP_C,
    MAP_NONE
  } chan_map_t;

  typedef struct packed {
    logic [RECS-1:0][REC_W-1:0] recs;
    logic [CNT_W-1:0]           count;
    logic [ERR_W-1:0]           err;
    logic [BUNCH_W-1:0]         bunch;
    logic [GRP_IDX_W-1:0]       grp;
    logic [WORD_W-1:0]          trig;
    chan_map_t                  cmap;
  } job_t;

  typedef struct packed {
    logic load;
    job_t job;
  } job_req_t;

  function automatic chan_map_t map_of(logic [WORD_W-1:0] src);
    chan_map_t m;
    if (src == SRC_A_LO || src == SRC_A_HI) begin
      m = MAP_A;
    end else if (src == SRC_C_LO || src == SRC_C_HI) begin
      m = MAP_C;
    end else begin
      m = MAP_NONE;
    end
    return m;
  endfunction

  // map a interleaves odd records into the upper half, map c the even ones
  function automatic logic [CHAN_W-1:0] chan_of(chan_map_t m, logic [IDX_W-1:0] i);
    logic [CHAN_W-1:0] c;
    unique case (m)
      MAP_A:   c = {i[0], i};
      MAP_C:   c = {~i[0], i};
      default: c = '0;
    endcase
    return c;
  endfunction

  // records complete once k words of a group are in
  function automatic logic [CNT_W-1:0] recs_done(logic [WPOS_W-1:0] k);
    logic [CNT_W-1:0] n;
    unique case (k)
      3'd2:    n = 4'd2;
      3'd3:    n = 4'd3;
      3'd4:    n = 4'd5;
      3'd5:    n = 4'd6;
      3'd6:    n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

### sv/hrgu_if.sv
interface hrgu_in_if;
  import hrgu_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              end_of_fragment;
  logic [WORD_W-1:0] source_id;
  logic [WORD_W-1:0] trigger_id;

  modport source (output valid, data_word, end_of_fragment, source_id, trigger_id,
                  input ready);
  modport sink   (input valid, data_word, end_of_fragment, source_id, trigger_id,
                  output ready);
endinterface

interface hrgu_out_if;
  import hrgu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAN_W-1:0]    channel;
  logic                 channel_unknown;
  logic [POS_W-1:0]     first_position;
  logic [WID_W-1:0]     first_width;
  logic [POS_W-1:0]     second_position;
  logic [WID_W-1:0]     second_width;
  logic [GRP_IDX_W-1:0] group_index;
  logic [BUNCH_W-1:0]   bunch_id;
  logic [WORD_W-1:0]    record_trigger_id;
  logic [ERR_W-1:0]     error_code;
  logic                 last;

  modport source (output valid, channel, channel_unknown, first_position, first_width,
                  second_position, second_width, group_index, bunch_id,
                  record_trigger_id, error_code, last,
                  input ready);
  modport sink   (input valid, channel, channel_unknown, first_position, first_width,
                  second_position, second_width, group_index, bunch_id,
                  record_trigger_id, error_code, last,
                  output ready);
endinterface

### sv/hrgu_emitter.sv
`include "hit_record_group_unpacker_defines.svh"

module hrgu_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  hrgu_pkg::job_req_t req,
  output logic              busy,
  hrgu_out_if.source        out_ch
);
  import hrgu_pkg::*;

  job_t             job_r;
  logic             job_v_r, job_v_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_v_r, out_v_nxt;
  logic             emit;
  logic             last_rec;
  logic [REC_W-1:0] rec;

  logic [CHAN_W-1:0]    chan_r;
  logic                 unk_r;
  logic [REC_W-1:0]     rec_r;
  logic [GRP_IDX_W-1:0] grp_r;
  logic [BUNCH_W-1:0]   bunch_r;
  logic [WORD_W-1:0]    trig_r;
  logic [ERR_W-1:0]     err_r;
  logic                 last_r;

  assign emit     = job_v_r && (!out_v_r || out_ch.ready);
  assign last_rec = (CNT_W'(idx_r) + CNT_W'(1)) == job_r.count;
  assign rec      = job_r.recs[idx_r];
  assign busy     = job_v_r;

  always_comb begin
    job_v_nxt = job_v_r;
    idx_nxt   = idx_r;
    if (req.load) begin
      job_v_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (emit) begin
      job_v_nxt = !last_rec;
      idx_nxt   = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      job_r <= req.job;
    end
    if (emit) begin
      chan_r  <= chan_of(job_r.cmap, idx_r);
      unk_r   <= (job_r.cmap != MAP_A) && (job_r.cmap != MAP_C);
      rec_r   <= rec;
      grp_r   <= job_r.grp;
      bunch_r <= job_r.bunch;
      trig_r  <= job_r.trig;
      err_r   <= job_r.err;
      last_r  <= last_rec;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.channel           = chan_r;
  assign out_ch.channel_unknown   = unk_r;
  assign out_ch.first_position    = rec_r[REC_W-1 -: POS_W];
  assign out_ch.first_width       = rec_r[REC_W-POS_W-1 -: WID_W];
  assign out_ch.second_position   = rec_r[WID_W+POS_W-1 -: POS_W];
  assign out_ch.second_width      = rec_r[WID_W-1:0];
  assign out_ch.group_index       = grp_r;
  assign out_ch.bunch_id          = bunch_r;
  assign out_ch.record_trigger_id = trig_r;
  assign out_ch.error_code        = err_r;
  assign out_ch.last              = last_r;

  `HRGU_ASSERT_IMP(a_idx_in_range, clk, rst_n, job_v_r, (CNT_W'(idx_r) < job_r.count), "record index beyond group count")
  `HRGU_ASSERT_IMP(a_no_overwrite, clk, rst_n, req.load, !job_v_r, "group loaded while previous still emitting")
  `HRGU_ASSERT_NXT(a_emit_shows, clk, rst_n, emit, out_v_r, "emitted record not presented")

endmodule

### sv/hit_record_group_unpacker.sv
// order: a beat that releases records loads the emitter's job register; the records
//   then pass the output register, one a cycle while out_ch is ready, to the last
// throughput: one word a cycle; a beat that completes a group or ends a fragment waits
//   while the record emitter still drains the previous group
// reset: rst_n synchronous, active low; clears word position, group counter and valid
//   flags; buffered words and record payload keep their contents
`include "hit_record_group_unpacker_defines.svh"

module hit_record_group_unpacker (
  input  logic       clk,
  input  logic       rst_n,
  hrgu_in_if.sink    in_ch,
  hrgu_out_if.source out_ch
);
  import hrgu_pkg::*;

  // words 0..4 of the group under assembly, written at the current position
  logic [WORD_W-1:0] gw_r [BUF_WORDS];

  logic [WPOS_W-1:0]    wpos_r, wpos_nxt;
  logic [GRP_CNT_W-1:0] grp_cnt_r, grp_cnt_nxt;

  logic     in_fire;
  logic     at_last;
  logic     busy;
  job_req_t req;

  // whole group as one bit string, word 0 at the top; words not yet in read as zero
  logic [WORDS_PER_GROUP*WORD_W-1:0] grp_bits;
  logic [CNT_W-1:0]                  rec_count;

  assign at_last = (wpos_r == LAST_WORD_POS);
  assign in_fire = in_ch.valid && in_ch.ready;

  // a beat that completes a group or ends a fragment needs the emitter free; the rest always go in
  assign in_ch.ready = !(busy && (at_last || in_ch.end_of_fragment));

  always_comb begin
    for (int j = 0; j < WORDS_PER_GROUP; j++) begin
      if (WPOS_W'(j) == wpos_r) begin
        grp_bits[(WORDS_PER_GROUP-1-j)*WORD_W +: WORD_W] = in_ch.data_word;
      end else if (j < BUF_WORDS && WPOS_W'(j) < wpos_r) begin
        grp_bits[(WORDS_PER_GROUP-1-j)*WORD_W +: WORD_W] = gw_r[j < BUF_WORDS ? j : 0];
      end else begin
        grp_bits[(WORDS_PER_GROUP-1-j)*WORD_W +: WORD_W] = '0;
      end
    end
  end

  // full group on word 5, else only the records already whole at end of fragment
  assign rec_count = (at_last || in_ch.end_of_fragment) ?
                     recs_done(wpos_r + WPOS_W'(1)) : '0;

  always_comb begin
    req.load = in_fire && (rec_count != '0);
    for (int i = 0; i < RECS; i++) begin
      // records are packed msb first, straight after the bunch id
      req.job.recs[i] = grp_bits[WORDS_PER_GROUP*WORD_W - BUNCH_W - REC_W*i - 1 -: REC_W];
    end
    req.job.count = rec_count;
    req.job.err   = at_last ? in_ch.data_word[ERR_W-1:0] : ERR_INCOMPLETE;
    req.job.bunch = grp_bits[WORDS_PER_GROUP*WORD_W-1 -: BUNCH_W];
    req.job.grp   = GRP_IDX_W'(grp_cnt_r);
    req.job.trig  = in_ch.trigger_id;
    req.job.cmap  = map_of(in_ch.source_id);
  end

  // position and group counter; end of fragment returns both to zero
  always_comb begin
    wpos_nxt    = wpos_r;
    grp_cnt_nxt = grp_cnt_r;
    if (in_fire) begin
      if (in_ch.end_of_fragment) begin
        wpos_nxt    = '0;
        grp_cnt_nxt = '0;
      end else if (at_last) begin
        wpos_nxt    = '0;
        grp_cnt_nxt = (grp_cnt_r == GRP_CNT_W'(MAX_GROUPS - 1)) ?
                      '0 : grp_cnt_r + GRP_CNT_W'(1);
      end else begin
        wpos_nxt = wpos_r + WPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r    <= '0;
      grp_cnt_r <= '0;
    end else begin
      wpos_r    <= wpos_nxt;
      grp_cnt_r <= grp_cnt_nxt;
    end
  end

  // word 5 is never kept: it goes straight into the record unpack
  always_ff @(posedge clk) begin
    if (in_fire && !at_last) begin
      gw_r[wpos_r] <= in_ch.data_word;
    end
  end

  hrgu_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .busy   (busy),
    .out_ch (out_ch)
  );

  `HRGU_ASSERT_IMP(a_wpos_range, clk, rst_n, 1'b1, (wpos_r <= LAST_WORD_POS), "word position beyond group")
  `HRGU_ASSERT_NXT(a_eof_clears, clk, rst_n, (in_fire && in_ch.end_of_fragment), (wpos_r == '0 && grp_cnt_r == '0), "end of fragment did not clear position")
  `HRGU_ASSERT_IMP(a_hold_on_busy, clk, rst_n, (busy && at_last), !in_ch.ready, "group completion accepted while emitter busy")

endmodule

### tb/hit_record_group_unpacker_tb.sv
`timescale 1ns / 100ps

module hit_record_group_unpacker_tb;
  import hrgu_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_WORDS = 375;
  localparam int SETTLE_TICKS = 20;
  // first record field starts right under the bunch id of word 0
  localparam int REC_TOP      = WORDS_PER_GROUP * WORD_W - BUNCH_W - 1;

  // channel maps for the two known source families, record 0 first
  localparam logic [CHAN_W-1:0] CHAN_SET_A [RECS] = '{4'd0, 4'd9, 4'd2, 4'd11,
                                                       4'd4, 4'd13, 4'd6, 4'd15};
  localparam logic [CHAN_W-1:0] CHAN_SET_C [RECS] = '{4'd8, 4'd1, 4'd10, 4'd3,
                                                       4'd12, 4'd5, 4'd14, 4'd7};
  // records fully held once n words of a group are in, n = 0..6
  localparam int RECS_BY_WORDS [WORDS_PER_GROUP + 1] = '{0, 0, 2, 3, 5, 6, 8};

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              eof;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] trig;
    int                gap;
    bit                settle;
  } frag_word_t;

  typedef struct {
    logic [CHAN_W-1:0]    channel;
    logic                 unknown;
    logic [POS_W-1:0]     first_pos;
    logic [WID_W-1:0]     first_wid;
    logic [POS_W-1:0]     second_pos;
    logic [WID_W-1:0]     second_wid;
    logic [GRP_IDX_W-1:0] group_idx;
    logic [BUNCH_W-1:0]   bunch;
    logic [WORD_W-1:0]    trig;
    logic [ERR_W-1:0]     err;
    logic                 last;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  hrgu_in_if  in_ch ();
  hrgu_out_if out_ch ();

  hit_record_group_unpacker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectations
  frag_word_t pending [$];
  hit_rec_t   expected_hits [$];

  // predictor state: buffered words of the open group, slot of next word, group number
  logic [WORD_W-1:0]    held_words [BUF_WORDS];
  int                   word_slot = 0;
  logic [GRP_IDX_W-1:0] group_num = '0;

  int  cycles       = 0;
  int  errors       = 0;
  int  words_taken  = 0;
  int  hits_checked = 0;
  int  fragments    = 0;
  int  partial_ends = 0;
  bit  in_busy      = 1'b0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;
  int  out_stall    = 0;
  int  calm_left    = 0;

  // work out the hit records that one accepted beat releases
  task automatic predict_hits(input frag_word_t w);
    logic [WORDS_PER_GROUP*WORD_W-1:0] flat;
    logic [REC_W-1:0]                  rec;
    logic [ERR_W-1:0]                  err;
    bit                                known_a, known_c;
    int                                n_words, n_out;
    hit_rec_t                          h;
    n_words = word_slot + 1;
    n_out   = 0;
    err     = ERR_INCOMPLETE;
    if (n_words == WORDS_PER_GROUP) begin
      n_out = RECS;
      err   = w.word[ERR_W-1:0];
    end else if (w.eof) begin
      n_out = RECS_BY_WORDS[n_words];
      partial_ends++;
    end
    // words not yet seen stay zero; they never reach a released record
    flat = '0;
    for (int i = 0; i < word_slot; i++) begin
      flat[(WORDS_PER_GROUP - 1 - i) * WORD_W +: WORD_W] = held_words[i];
    end
    flat[(WORDS_PER_GROUP - 1 - word_slot) * WORD_W +: WORD_W] = w.word;
    known_a = (w.src == SRC_A_LO) || (w.src == SRC_A_HI);
    known_c = (w.src == SRC_C_LO) || (w.src == SRC_C_HI);
    for (int i = 0; i < n_out; i++) begin
      rec          = flat[REC_TOP - REC_W * i -: REC_W];
      h.channel    = known_a ? CHAN_SET_A[i] : (known_c ? CHAN_SET_C[i] : '0);
      h.unknown    = !(known_a || known_c);
      h.first_pos  = rec[21:16];
      h.first_wid  = rec[15:11];
      h.second_pos = rec[10:5];
      h.second_wid = rec[4:0];
      h.group_idx  = group_num;
      h.bunch      = flat[WORDS_PER_GROUP * WORD_W - 1 -: BUNCH_W];
      h.trig       = w.trig;
      h.err        = err;
      h.last       = (i == n_out - 1);
      expected_hits.insert(expected_hits.size(), h);
    end
    if (word_slot < BUF_WORDS) begin
      held_words[word_slot] = w.word;
    end
    if (w.eof) begin
      word_slot = 0;
      group_num = '0;
    end else if (n_words == WORDS_PER_GROUP) begin
      word_slot = 0;
      group_num = GRP_IDX_W'((int'(group_num) + 1) % MAX_GROUPS);
    end else begin
      word_slot = n_words;
    end
  endtask

  // compare one received record with the oldest expectation
  task automatic check_hit(input hit_rec_t got);
    hit_rec_t want;
    if (expected_hits.size() == 0) begin
      $error("unexpected hit record: channel %0d group %0d", got.channel, got.group_idx);
      errors++;
    end else begin
      want = expected_hits.pop_front();
      if (got.channel !== want.channel) begin
        $error("channel: expected %0d, got %0d", want.channel, got.channel);
        errors++;
      end
      if (got.unknown !== want.unknown) begin
        $error("channel_unknown: expected %0d, got %0d", want.unknown, got.unknown);
        errors++;
      end
      if (got.first_pos !== want.first_pos) begin
        $error("first_position: expected %0d, got %0d", want.first_pos, got.first_pos);
        errors++;
      end
      if (got.first_wid !== want.first_wid) begin
        $error("first_width: expected %0d, got %0d", want.first_wid, got.first_wid);
        errors++;
      end
      if (got.second_pos !== want.second_pos) begin
        $error("second_position: expected %0d, got %0d", want.second_pos, got.second_pos);
        errors++;
      end
      if (got.second_wid !== want.second_wid) begin
        $error("second_width: expected %0d, got %0d", want.second_wid, got.second_wid);
        errors++;
      end
      if (got.group_idx !== want.group_idx) begin
        $error("group_index: expected %0d, got %0d", want.group_idx, got.group_idx);
        errors++;
      end
      if (got.bunch !== want.bunch) begin
        $error("bunch_id: expected 0x%03h, got 0x%03h", want.bunch, got.bunch);
        errors++;
      end
      if (got.trig !== want.trig) begin
        $error("record_trigger_id: expected 0x%08h, got 0x%08h", want.trig, got.trig);
        errors++;
      end
      if (got.err !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, got.err);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  // known ids, near misses of a known id, and anything at all
  function automatic logic [WORD_W-1:0] pick_source();
    logic [WORD_W-1:0] s;
    case ($urandom_range(0, 5))
      0:       s = SRC_A_LO;
      1:       s = SRC_A_HI;
      2:       s = SRC_C_LO;
      3:       s = SRC_C_HI;
      4:       s = SRC_C_HI ^ (32'd1 << $urandom_range(0, 31));
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // queue one fragment; calm drops the sender gaps, settle holds its first word
  // until every outstanding record has come back
  task automatic add_fragment(input logic [WORD_W-1:0] src, input int n_words,
                              input fill_t fill, input bit calm, input bit settle);
    frag_word_t w;
    logic [WORD_W-1:0] trig;
    trig = $urandom;
    for (int i = 0; i < n_words; i++) begin
      case (fill)
        FILL_ONES:  w.word = '1;
        FILL_ZEROS: w.word = '0;
        default:    w.word = $urandom;
      endcase
      w.eof = (i == n_words - 1);
      // fragment-wide fields are sampled per beat, so stray changes are fair game
      w.src = ($urandom_range(0, 31) == 0) ? pick_source() : src;
      if ($urandom_range(0, 15) == 0) begin
        trig = $urandom;
      end
      w.trig   = trig;
      w.gap    = calm ? 0 : $urandom_range(0, 13);
      w.settle = settle && (i == 0);
      pending.insert(pending.size(), w);
    end
    fragments++;
  endtask

  // hold until every queued beat is in and every expected record is out
  task automatic wait_drained();
    while (pending.size() != 0 || in_busy || expected_hits.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    hit_rec_t got;
    cycles++;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_hits('{word: in_ch.data_word, eof: in_ch.end_of_fragment,
                       src: in_ch.source_id, trig: in_ch.trigger_id,
                       gap: 0, settle: 1'b0});
        words_taken++;
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.channel    = out_ch.channel;
        got.unknown    = out_ch.channel_unknown;
        got.first_pos  = out_ch.first_position;
        got.first_wid  = out_ch.first_width;
        got.second_pos = out_ch.second_position;
        got.second_wid = out_ch.second_width;
        got.group_idx  = out_ch.group_index;
        got.bunch      = out_ch.bunch_id;
        got.trig       = out_ch.record_trigger_id;
        got.err        = out_ch.error_code;
        got.last       = out_ch.last;
        check_hit(got);
        hits_checked++;
        out_taken = 1'b1;
      end
    end
  end

  // word driver: a beat stays up until taken, then the next one waits out its gap
  always @(negedge clk) begin
    frag_word_t cur;
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy  = 1'b0;
    end
    if (!in_busy) begin
      if (pending.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending[0].gap > 0) begin
        pending[0].gap = pending[0].gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending[0].settle && expected_hits.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        cur = pending.pop_front();
        in_ch.data_word       <= cur.word;
        in_ch.end_of_fragment <= cur.eof;
        in_ch.source_id       <= cur.src;
        in_ch.trigger_id      <= cur.trig;
        in_ch.valid           <= 1'b1;
        in_busy = 1'b1;
      end
    end
  end

  // record sink: random stall after each record, with calm stretches now and then
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if (calm_left > 0) begin
        calm_left--;
        out_stall = 0;
      end else begin
        out_stall = $urandom_range(0, 13);
        if ($urandom_range(0, 15) == 0) begin
          calm_left = 48;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // run guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int    tail;
    int    groups;
    fill_t fill;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.data_word       = '0;
    in_ch.end_of_fragment = 1'b0;
    in_ch.source_id       = '0;
    in_ch.trigger_id      = '0;
    out_ch.ready          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: full group closed by end of fragment, all ones
    add_fragment(SRC_A_LO, WORDS_PER_GROUP, FILL_ONES, 1'b0, 1'b0);
    // full group of zeros, then a lone word ending the fragment with nothing to release
    add_fragment(SRC_C_HI, WORDS_PER_GROUP + 1, FILL_ZEROS, 1'b0, 1'b0);
    // fragments cut short after five, four, three and two words
    add_fragment(SRC_A_HI, 5, FILL_RANDOM, 1'b0, 1'b0);
    add_fragment(32'h0000_0000, 4, FILL_RANDOM, 1'b0, 1'b0);
    add_fragment(SRC_C_LO, 3, FILL_RANDOM, 1'b0, 1'b0);
    add_fragment(32'hFFFF_FFFF, 2, FILL_ONES, 1'b1, 1'b0);
    // sender holds back until all records of the directed part are home
    wait_drained();

    // random fragments, mostly whole groups with a ragged tail
    while (pending.size() < RANDOM_WORDS) begin
      groups = $urandom_range(0, 4);
      tail   = $urandom_range(0, 5);
      if (groups == 0 && tail == 0) begin
        tail = 1;
      end
      case ($urandom_range(0, 9))
        0:       fill = FILL_ONES;
        1:       fill = FILL_ZEROS;
        default: fill = FILL_RANDOM;
      endcase
      add_fragment(pick_source(), groups * WORDS_PER_GROUP + tail, fill,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
    end
    wait_drained();

    repeat (SETTLE_TICKS) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $error("%0d expected hit records never arrived", expected_hits.size());
      errors++;
    end

    $display("run covered %0d words in %0d fragments (%0d cut mid-group), %0d records checked",
             words_taken, fragments, partial_ends, hits_checked);
    $display("random gaps and stalls on both sides, with drained pauses; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hrgu_pkg.sv
sv/hrgu_if.sv
sv/hrgu_emitter.sv
sv/hit_record_group_unpacker.sv
tb/hit_record_group_unpacker_tb.sv
